// ===== rtl/lslf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lslf_pkg: shared definitions for the least-squares line fit unit
// Widths, operand select codes, status codes and the controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
package lslf_pkg;

	localparam int MAX_POINTS = 256;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	localparam int XY_W   = 16;
	localparam int SX_W   = 25;
	localparam int SXY_W  = 40;
	localparam int SXX_W  = 39;

	// shared multiplier: |A| split into two halves, each times |B|
	localparam int OPA_W  = 40;
	localparam int OPB_W  = 25;
	localparam int HALF_W = OPA_W / 2;
	localparam int PROD_W = HALF_W + OPB_W;
	localparam int ACC_W  = 66;

	// divider
	localparam int DEN_W     = 48;
	localparam int DVD_W     = 72;
	localparam int DIV_BITS  = DVD_W;
	localparam int DIV_CNT_W = $clog2(DIV_BITS + 2);
	localparam int Q_W       = 33;
	localparam int RES_W     = 32;
	localparam int SLOPE_SH  = 16;
	localparam int ICPT_SH   = 8;

	// product select codes, ordered as {term, second product of term}
	localparam logic [2:0] PR_N_SXX  = 3'd0;
	localparam logic [2:0] PR_SX_SX  = 3'd1;
	localparam logic [2:0] PR_N_SXY  = 3'd2;
	localparam logic [2:0] PR_SX_SY  = 3'd3;
	localparam logic [2:0] PR_SXX_SY = 3'd4;
	localparam logic [2:0] PR_SX_SXY = 3'd5;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_DEGEN    = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;

	typedef struct packed {
		logic       acc_en;
		logic       mul_issue;
		logic [2:0] mul_sel;
		logic       mul_hi;
		logic       mul_neg;
		logic       store_den;
		logic       store_na;
		logic       store_nb;
		logic       div_load;
		logic       div_icpt;
		logic       div_step;
		logic       div_store;
		logic       out_load;
		logic [1:0] out_status;
		logic       clear_sums;
	} lslf_cmd_t;

	typedef struct packed {
		logic overflow;
		logic den_pos;
		logic out_free;
	} lslf_stat_t;

endpackage
`default_nettype wire

// ===== rtl/lslf_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lslf_dp: datapath of the line fit unit
// Running sums, shared split multiplier with accumulator, restoring divider
// with saturation, and the output register.
// ----------------------------------------------------------------------------
module lslf_dp (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire  lslf_pkg::lslf_cmd_t   cmd,
	output lslf_pkg::lslf_stat_t        stat,
	input  wire  [lslf_pkg::XY_W-1:0]   x_value,
	input  wire  [lslf_pkg::XY_W-1:0]   y_value,
	output logic                        m_axis_tvalid,
	input  wire                         m_axis_tready,
	output logic [2*lslf_pkg::RES_W-1:0] m_axis_tdata,  // intercept (high), slope (low)
	output logic [1:0]                  m_axis_tuser   // status
);
	import lslf_pkg::*;

	// running sums
	logic [CNT_W-1:0]        count_q;
	logic                    ovf_q;
	logic signed [SX_W-1:0]  sum_x_q;
	logic signed [SX_W-1:0]  sum_y_q;
	logic signed [SXY_W-1:0] sum_xy_q;
	logic [SXX_W-1:0]        sum_xx_q;

	logic signed [XY_W-1:0]   x_s, y_s;
	logic signed [2*XY_W-1:0] xy_prod, xx_prod;

	assign x_s     = signed'(x_value);
	assign y_s     = signed'(y_value);
	assign xy_prod = x_s * y_s;
	assign xx_prod = x_s * x_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xy_q <= '0;
			sum_xx_q <= '0;
		end else if (cmd.clear_sums) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xy_q <= '0;
			sum_xx_q <= '0;
		end else if (cmd.acc_en) begin
			if (count_q == CNT_W'(MAX_POINTS)) begin
				ovf_q <= 1'b1;
			end else begin
				count_q  <= count_q + 1'b1;
				sum_x_q  <= sum_x_q + SX_W'(x_s);
				sum_y_q  <= sum_y_q + SX_W'(y_s);
				sum_xy_q <= sum_xy_q + SXY_W'(xy_prod);
				sum_xx_q <= sum_xx_q + SXX_W'(xx_prod[2*XY_W-2:0]);
			end
		end
	end

	// operand select
	logic signed [OPA_W-1:0] opa;
	logic signed [OPB_W-1:0] opb;
	logic [OPA_W-1:0]        mag_a;
	logic [OPB_W-1:0]        mag_b;

	always_comb begin
		case (cmd.mul_sel)
			PR_N_SXX: begin
				opa = signed'(OPA_W'(sum_xx_q));
				opb = signed'(OPB_W'(count_q));
			end
			PR_SX_SX: begin
				opa = OPA_W'(sum_x_q);
				opb = sum_x_q;
			end
			PR_N_SXY: begin
				opa = sum_xy_q;
				opb = signed'(OPB_W'(count_q));
			end
			PR_SX_SY: begin
				opa = OPA_W'(sum_x_q);
				opb = sum_y_q;
			end
			PR_SXX_SY: begin
				opa = signed'(OPA_W'(sum_xx_q));
				opb = sum_y_q;
			end
			PR_SX_SXY: begin
				opa = sum_xy_q;
				opb = sum_x_q;
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
		mag_a = opa[OPA_W-1] ? unsigned'(-opa) : unsigned'(opa);
		mag_b = opb[OPB_W-1] ? unsigned'(-opb) : unsigned'(opb);
	end

	// multiply pipeline: operands, product, accumulate
	logic [HALF_W-1:0] opa_s1;
	logic [OPB_W-1:0]  opb_s1;
	logic              vld_s1, hi_s1, neg_s1;
	logic [PROD_W-1:0] prod_s2;
	logic              vld_s2, hi_s2, neg_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0]  prod_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.mul_issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		opa_s1  <= cmd.mul_hi ? mag_a[OPA_W-1:HALF_W] : mag_a[HALF_W-1:0];
		opb_s1  <= mag_b;
		hi_s1   <= cmd.mul_hi;
		neg_s1  <= opa[OPA_W-1] ^ opb[OPB_W-1] ^ cmd.mul_neg;
		prod_s2 <= PROD_W'(opa_s1) * PROD_W'(opb_s1);
		hi_s2   <= hi_s1;
		neg_s2  <= neg_s1;
	end

	assign prod_ext = hi_s2 ? ACC_W'({prod_s2, {HALF_W{1'b0}}}) : ACC_W'(prod_s2);

	logic [DEN_W-1:0]        den_q;
	logic                    den_pos_q;
	logic signed [ACC_W-1:0] na_q, nb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			den_pos_q <= 1'b0;
		end else if (cmd.store_den || cmd.store_na || cmd.store_nb) begin
			acc_q <= '0;
			if (cmd.store_den)
				den_pos_q <= !acc_q[ACC_W-1] && (acc_q != '0);
		end else if (vld_s2) begin
			acc_q <= neg_s2 ? acc_q - signed'(prod_ext) : acc_q + signed'(prod_ext);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_den)
			den_q <= acc_q[DEN_W-1:0];
		if (cmd.store_na)
			na_q <= acc_q;
		if (cmd.store_nb)
			nb_q <= acc_q;
	end

	// restoring divider, one quotient bit per cycle
	logic signed [ACC_W-1:0] num;
	logic [ACC_W-1:0]        num_mag;
	logic [DVD_W-1:0]        dvd_init;
	logic [DVD_W-1:0]        dvd_q;
	logic [DEN_W-1:0]        rem_q;
	logic [Q_W-1:0]          q_q;
	logic                    sticky_q, qneg_q;
	logic [DEN_W:0]          trial;
	logic                    ge;
	logic                    big;
	logic [RES_W-1:0]        res;
	logic [RES_W-1:0]        slope_q, icpt_q;

	assign num      = cmd.div_icpt ? nb_q : na_q;
	assign num_mag  = num[ACC_W-1] ? unsigned'(-num) : unsigned'(num);
	assign dvd_init = cmd.div_icpt ?
		{num_mag[DVD_W-ICPT_SH-1:0], {ICPT_SH{1'b0}}} :
		{num_mag[DVD_W-SLOPE_SH-1:0], {SLOPE_SH{1'b0}}};
	assign trial    = {rem_q, dvd_q[DVD_W-1]};
	assign ge       = trial >= {1'b0, den_q};
	assign big      = sticky_q | q_q[Q_W-1];

	always_comb begin
		if (!qneg_q)
			res = (big || q_q[RES_W-1]) ? {1'b0, {(RES_W-1){1'b1}}} : q_q[RES_W-1:0];
		else if (big || (q_q[RES_W-1] && (q_q[RES_W-2:0] != '0)))
			res = {1'b1, {(RES_W-1){1'b0}}};
		else
			res = -q_q[RES_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			dvd_q    <= dvd_init;
			rem_q    <= '0;
			q_q      <= '0;
			sticky_q <= 1'b0;
			qneg_q   <= num[ACC_W-1];
		end else if (cmd.div_step) begin
			dvd_q    <= dvd_q << 1;
			rem_q    <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			q_q      <= {q_q[Q_W-2:0], ge};
			sticky_q <= sticky_q | q_q[Q_W-1];
		end
		if (cmd.div_store) begin
			if (cmd.div_icpt)
				icpt_q <= res;
			else
				slope_q <= res;
		end
	end

	// output register
	logic out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (cmd.out_load)
			out_vld_q <= 1'b1;
		else if (m_axis_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_axis_tdata <= (cmd.out_status == STAT_OK) ? {icpt_q, slope_q} : '0;
			m_axis_tuser <= cmd.out_status;
		end
	end

	assign m_axis_tvalid = out_vld_q;

	assign stat.overflow = ovf_q;
	assign stat.den_pos  = den_pos_q;
	assign stat.out_free = !out_vld_q || m_axis_tready;

endmodule
`default_nettype wire

// ===== rtl/lslf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lslf_ctrl: sequencer of the line fit unit
// Accepts points, steps the multiplier through the three normal equation
// terms, runs the two divisions if status is OK, loads the output register.
// ----------------------------------------------------------------------------
module lslf_ctrl (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_axis_tvalid,
	input  wire                        s_axis_tlast,
	output logic                       s_axis_tready,
	input  wire  lslf_pkg::lslf_stat_t stat,
	output lslf_pkg::lslf_cmd_t        cmd
);
	import lslf_pkg::*;

	localparam logic [1:0] ST_ACC = 2'd0;
	localparam logic [1:0] ST_MUL = 2'd1;
	localparam logic [1:0] ST_DIV = 2'd2;
	localparam logic [1:0] ST_OUT = 2'd3;

	localparam logic [1:0] TERM_DEN = 2'd0;
	localparam logic [1:0] TERM_NA  = 2'd1;
	localparam logic [1:0] TERM_NB  = 2'd2;

	// four issues, then the store once the last product is accumulated
	localparam logic [2:0] STEP_LAST_ISSUE = 3'd3;
	localparam logic [2:0] STEP_STORE      = 3'd6;
	localparam logic [DIV_CNT_W-1:0] DIV_CNT_STORE = DIV_CNT_W'(DIV_BITS + 1);

	logic [1:0]           state_q;
	logic [1:0]           term_q;
	logic [2:0]           step_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 icpt_q;

	always_comb begin
		cmd           = '0;
		s_axis_tready = 1'b0;
		cmd.div_icpt  = icpt_q;
		case (state_q)
			ST_ACC: begin
				s_axis_tready = 1'b1;
				cmd.acc_en    = s_axis_tvalid;
			end
			ST_MUL: begin
				if (step_q <= STEP_LAST_ISSUE) begin
					cmd.mul_issue = 1'b1;
					cmd.mul_sel   = {term_q, step_q[1]};
					cmd.mul_hi    = step_q[0];
					cmd.mul_neg   = step_q[1];
				end
				if (step_q == STEP_STORE) begin
					case (term_q)
						TERM_DEN: cmd.store_den = 1'b1;
						TERM_NA:  cmd.store_na  = 1'b1;
						TERM_NB:  cmd.store_nb  = 1'b1;
						default:  cmd.store_nb  = 1'b0;
					endcase
				end
			end
			ST_DIV: begin
				if (div_cnt_q == '0)
					cmd.div_load = 1'b1;
				else if (div_cnt_q == DIV_CNT_STORE)
					cmd.div_store = 1'b1;
				else
					cmd.div_step = 1'b1;
			end
			ST_OUT: begin
				cmd.out_load   = stat.out_free;
				cmd.clear_sums = stat.out_free;
			end
			default: ;
		endcase
		if (stat.overflow)
			cmd.out_status = STAT_OVERFLOW;
		else if (!stat.den_pos)
			cmd.out_status = STAT_DEGEN;
		else
			cmd.out_status = STAT_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_ACC;
			term_q    <= TERM_DEN;
			step_q    <= '0;
			div_cnt_q <= '0;
			icpt_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_ACC: begin
					if (s_axis_tvalid && s_axis_tlast) begin
						state_q <= ST_MUL;
						term_q  <= TERM_DEN;
						step_q  <= '0;
					end
				end
				ST_MUL: begin
					if (step_q == STEP_STORE) begin
						step_q <= '0;
						if (term_q == TERM_NB) begin
							div_cnt_q <= '0;
							icpt_q    <= 1'b0;
							state_q   <= (!stat.overflow && stat.den_pos) ? ST_DIV : ST_OUT;
						end else begin
							term_q <= term_q + 1'b1;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == DIV_CNT_STORE) begin
						div_cnt_q <= '0;
						if (icpt_q)
							state_q <= ST_OUT;
						else
							icpt_q <= 1'b1;
					end else begin
						div_cnt_q <= div_cnt_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (stat.out_free)
						state_q <= ST_ACC;
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/least_squares_line_fit_unit.sv =====
`default_nettype none
// Points are taken one per cycle; a point marked last stalls the input until
// its result is in the output register.
// After the last point the fit runs the three terms on the shared split
// multiplier, then the two divisions in the one-bit-per-cycle divider, then
// loads the output; when status is nonzero the divisions are skipped.
// Asynchronous active-low reset clears the count, all sums and the output valid.
// ----------------------------------------------------------------------------
// least_squares_line_fit_unit: streaming least-squares line fit
// Accumulates Q8.8 points and on the last one returns slope and intercept
// in Q16.16 with a status code.
// ----------------------------------------------------------------------------
module least_squares_line_fit_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,  // y_value (high), x_value (low)
	input  wire         s_axis_tlast,  // last_point
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [63:0] m_axis_tdata,  // intercept (high), slope (low)
	output logic [1:0]  m_axis_tuser   // status
);
	import lslf_pkg::*;

	lslf_cmd_t  cmd;
	lslf_stat_t stat;

	lslf_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	lslf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.x_value       (s_axis_tdata[XY_W-1:0]),
		.y_value       (s_axis_tdata[2*XY_W-1:XY_W]),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// the fit runs with the input held off
	a_stall_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
		else $error("input accepted right after last point");

	// failed fits carry zero slope and intercept
	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != STAT_OK)) |-> (m_axis_tdata == '0))
		else $error("nonzero fit data with error status");

	// a new point never lands while the sequencer is busy
	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul_issue || cmd.div_step) |-> !cmd.acc_en)
		else $error("point accumulated during fit");

endmodule
`default_nettype wire
